/* rtl/core/owr_pkg.sv */
// Shared types, codes and constants of the one-wire bus master.
`timescale 1ns / 1ps

package owr_pkg;

    localparam int TIMER_BITS_DEF = 10;
    localparam int DUR_W = 10;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [7:0] ROM_SKIP = 8'hCC;
    localparam logic [7:0] FN_CONVERT = 8'h44;
    localparam logic [7:0] FN_READ_PAD = 8'hBE;
    localparam logic [DUR_W-1:0] READ_GAP = 10'd2;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_RESET = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_TEMP  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        PRES_OK   = 2'd0,
        PRES_NONE = 2'd1,
        PRES_LONG = 2'd2
    } pres_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 4'd0,
        CFG_RESET_RELEASE = 4'd1,
        CFG_PRES_TIMEOUT  = 4'd2,
        CFG_PRES_LIMIT    = 4'd3,
        CFG_SHORT_LOW     = 4'd4,
        CFG_LONG_LOW      = 4'd5,
        CFG_SAMPLE_DELAY  = 4'd6,
        CFG_RECOVER       = 4'd7
    } cfg_idx_t;

    localparam logic [3:0] STEP_RST_A = 4'd0;
    localparam logic [3:0] STEP_SKIP_A = 4'd1;
    localparam logic [3:0] STEP_CONVERT = 4'd2;
    localparam logic [3:0] STEP_RST_B = 4'd3;
    localparam logic [3:0] STEP_SKIP_B = 4'd4;
    localparam logic [3:0] STEP_READ_PAD = 4'd5;
    localparam logic [3:0] STEP_LOW_BYTE = 4'd6;
    localparam logic [3:0] STEP_HIGH_BYTE = 4'd7;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RST_LOW   = 10'b00_0000_0010,
        PH_RST_REL   = 10'b00_0000_0100,
        PH_PRES_WAIT = 10'b00_0000_1000,
        PH_PRES_LOW  = 10'b00_0001_0000,
        PH_WR_LOW    = 10'b00_0010_0000,
        PH_WR_REL    = 10'b00_0100_0000,
        PH_RD_LOW    = 10'b00_1000_0000,
        PH_RD_WAIT   = 10'b01_0000_0000,
        PH_RD_REC    = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] reset_release_time;
        logic [9:0] presence_timeout;
        logic [9:0] presence_low_limit;
        logic [7:0] short_low_time;
        logic [7:0] long_low_time;
        logic [7:0] read_sample_delay;
        logic [7:0] read_recover_time;
    } owr_cfg_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        presence_status;
        logic [7:0]        read_data;
        logic signed [15:0] temperature;
    } owr_res_t;

endpackage

/* rtl/core/owr_if.sv */
// Handshake channel interfaces for ticks, results and configuration writes.
`timescale 1ns / 1ps

interface owr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output opcode, output data_byte, output line_level,
                    input ready);
    modport sink (input valid, input opcode, input data_byte, input line_level,
                  output ready);
endinterface

interface owr_out_if;
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         presence_status;
    logic [7:0]         read_data;
    logic signed [15:0] temperature;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence_status, output read_data, output temperature,
                    input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence_status, input read_data, input temperature,
                  output ready);
endinterface

interface owr_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/one_wire_master_temperature_read.sv */
// Top level of the one-wire bus master with its result register.
`timescale 1ns / 1ps

// Each input beat is one microsecond tick carrying the sampled line level and, while the
// master is idle, an optional command (reset and presence check, write byte, read byte,
// or a full temperature read). Unless the output stalls, one beat is taken every clock;
// its result beat, holding the line drive, status and last read values after that tick,
// is in the output register from the next clock on. The bus timing sequencer updates
// once per tick, so the rate is one tick per cycle if unstalled, set by that single
// registered pass. The temperature is a signed count of sixteenths of a degree.
// Configuration writes are taken at any time and are meant to be issued while no command runs.
module one_wire_master_temperature_read
    import owr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    owr_in_if.sink    tick,
    owr_out_if.source result,
    owr_cfg_if.sink   cfg_wr
);

    owr_cfg_t cfg;
    owr_res_t core_res;
    owr_res_t res_reg;
    logic     out_valid_reg;
    logic     tick_accept;

    assign cfg_wr.ready = 1'b1;
    assign tick.ready   = !out_valid_reg || result.ready;
    assign tick_accept  = tick.valid && tick.ready;

    owr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr.valid),
        .wr_index (cfg_wr.index),
        .wr_data  (cfg_wr.data),
        .cfg      (cfg)
    );

    owr_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (tick_accept),
        .opcode     (tick.opcode),
        .data_byte  (tick.data_byte),
        .line_level (tick.line_level),
        .cfg        (cfg),
        .res        (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
            res_reg <= core_res;
    end

    assign result.valid           = out_valid_reg;
    assign result.drive_low       = res_reg.drive_low;
    assign result.busy_res        = res_reg.busy_res;
    assign result.done_res        = res_reg.done_res;
    assign result.presence_status = res_reg.presence_status;
    assign result.read_data       = res_reg.read_data;
    assign result.temperature     = res_reg.temperature;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !tick.ready)
        else $error("tick taken while a result beat is stalled");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> out_valid_reg)
        else $error("accepted tick produced no result beat");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done flagged while still busy");

    a_drive_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.drive_low) |-> res_reg.busy_res)
        else $error("line driven low while idle");

endmodule

/* rtl/core/owr_cfg.sv */
// Configuration register file of the one-wire bus master.
`timescale 1ns / 1ps

module owr_cfg
    import owr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output owr_cfg_t              cfg
);

    owr_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time     <= 10'd750;
            cfg_reg.reset_release_time <= 8'd15;
            cfg_reg.presence_timeout   <= 10'd200;
            cfg_reg.presence_low_limit <= 10'd240;
            cfg_reg.short_low_time     <= 8'd2;
            cfg_reg.long_low_time      <= 8'd60;
            cfg_reg.read_sample_delay  <= 8'd12;
            cfg_reg.read_recover_time  <= 8'd50;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_RESET_LOW:     cfg_reg.reset_low_time     <= wr_data;
                CFG_RESET_RELEASE: cfg_reg.reset_release_time <= wr_data[7:0];
                CFG_PRES_TIMEOUT:  cfg_reg.presence_timeout   <= wr_data;
                CFG_PRES_LIMIT:    cfg_reg.presence_low_limit <= wr_data;
                CFG_SHORT_LOW:     cfg_reg.short_low_time     <= wr_data[7:0];
                CFG_LONG_LOW:      cfg_reg.long_low_time      <= wr_data[7:0];
                CFG_SAMPLE_DELAY:  cfg_reg.read_sample_delay  <= wr_data[7:0];
                CFG_RECOVER:       cfg_reg.read_recover_time  <= wr_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/owr_core.sv */
// Timed bus sequencer: state registers and the per-tick next-state logic.
`timescale 1ns / 1ps

module owr_core
    import owr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_en,
    input  logic [2:0] opcode,
    input  logic [7:0] data_byte,
    input  logic       line_level,
    input  owr_cfg_t   cfg,
    output owr_res_t   res
);

    localparam int CMP_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_reg, shift_next;
    logic [3:0]            step_reg, step_next;
    logic [2:0]            command_reg, command_next;
    logic [7:0]            low_byte_reg, low_byte_next;
    logic [1:0]            status_reg, status_next;
    logic [15:0]           temp_reg, temp_next;
    logic [7:0]            read_reg, read_next;
    logic                  done;

    function automatic logic [TIMER_BITS-1:0] clamp_dur(input logic [DUR_W-1:0] d);
        logic [CMP_W-1:0] dw;
        dw = CMP_W'(d);
        if (d == '0)
            return TIMER_BITS'(1);
        else if (dw > CMP_W'(TIMER_MAX))
            return TIMER_MAX;
        else
            return TIMER_BITS'(dw);
    endfunction

    always_comb
    begin
        logic       start;
        logic       finish;
        logic [3:0] start_step;
        logic [7:0] wr_byte;
        logic       do_write;
        logic       do_read;
        logic       do_reset;
        logic [3:0] bits_inc;

        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        step_next      = step_reg;
        command_next   = command_reg;
        low_byte_next  = low_byte_reg;
        status_next    = status_reg;
        temp_next      = temp_reg;
        read_next      = read_reg;
        done           = 1'b0;
        start          = 1'b0;
        finish         = 1'b0;
        start_step     = 4'd0;
        wr_byte        = 8'd0;
        do_write       = 1'b0;
        do_read        = 1'b0;
        do_reset       = 1'b0;
        bits_inc       = bit_count_reg + 4'd1;

        case (phase_reg)
            PH_IDLE:
            begin
                if (opcode >= OP_RESET && opcode <= OP_TEMP)
                begin
                    command_next = opcode;
                    step_next    = 4'd0;
                    shift_next   = data_byte;
                    start        = 1'b1;
                    start_step   = 4'd0;
                end
            end
            PH_RST_LOW:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    phase_next = PH_RST_REL;
                    timer_next = clamp_dur(DUR_W'(cfg.reset_release_time));
                end
            end
            PH_RST_REL:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    phase_next = PH_PRES_WAIT;
                    timer_next = '0;
                end
            end
            PH_PRES_WAIT:
            begin
                if (!line_level)
                begin
                    phase_next = PH_PRES_LOW;
                    timer_next = '0;
                end
                else
                begin
                    if (timer_reg != TIMER_MAX)
                        timer_next = timer_reg + TIMER_BITS'(1);
                    if (timer_next >= clamp_dur(cfg.presence_timeout))
                    begin
                        status_next = PRES_NONE;
                        finish      = 1'b1;
                    end
                end
            end
            PH_PRES_LOW:
            begin
                if (line_level)
                begin
                    status_next = PRES_OK;
                    finish      = 1'b1;
                end
                else
                begin
                    if (timer_reg != TIMER_MAX)
                        timer_next = timer_reg + TIMER_BITS'(1);
                    if (timer_next >= clamp_dur(cfg.presence_low_limit))
                    begin
                        status_next = PRES_LONG;
                        finish      = 1'b1;
                    end
                end
            end
            PH_WR_LOW:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    phase_next = PH_WR_REL;
                    timer_next = shift_reg[0] ? clamp_dur(DUR_W'(cfg.long_low_time))
                                              : clamp_dur(DUR_W'(cfg.short_low_time));
                end
            end
            PH_WR_REL:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    shift_next     = {1'b0, shift_reg[7:1]};
                    bit_count_next = bits_inc;
                    if (bits_inc >= 4'd8)
                        finish = 1'b1;
                    else
                    begin
                        phase_next = PH_WR_LOW;
                        timer_next = shift_next[0] ? clamp_dur(DUR_W'(cfg.short_low_time))
                                                   : clamp_dur(DUR_W'(cfg.long_low_time));
                    end
                end
            end
            PH_RD_LOW:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    phase_next = PH_RD_WAIT;
                    timer_next = clamp_dur(DUR_W'(cfg.read_sample_delay));
                end
            end
            PH_RD_WAIT:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    shift_next = {line_level, shift_reg[7:1]};
                    phase_next = PH_RD_REC;
                    timer_next = clamp_dur(DUR_W'(cfg.read_recover_time) + READ_GAP);
                end
            end
            PH_RD_REC:
            begin
                if (timer_reg > TIMER_BITS'(1))
                    timer_next = timer_reg - TIMER_BITS'(1);
                else
                begin
                    bit_count_next = bits_inc;
                    if (bits_inc >= 4'd8)
                    begin
                        read_next = shift_reg;
                        if (command_reg == OP_TEMP && step_reg == STEP_LOW_BYTE)
                            low_byte_next = shift_reg;
                        if (command_reg == OP_TEMP && step_reg == STEP_HIGH_BYTE)
                            temp_next = {shift_reg, low_byte_reg};
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RD_LOW;
                        timer_next = clamp_dur(DUR_W'(cfg.short_low_time));
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        endcase

        if (finish)
        begin
            step_next  = step_reg + 4'd1;
            start      = 1'b1;
            start_step = step_reg + 4'd1;
        end

        // Pick the next bus action of the running command.
        if (start)
        begin
            case (command_next)
                OP_RESET:
                    do_reset = (start_step == 4'd0);
                OP_WRITE:
                begin
                    do_write = (start_step == 4'd0);
                    wr_byte  = shift_next;
                end
                OP_READ:
                    do_read = (start_step == 4'd0);
                OP_TEMP:
                begin
                    case (start_step)
                        STEP_RST_A, STEP_RST_B:
                            do_reset = 1'b1;
                        STEP_SKIP_A, STEP_SKIP_B:
                        begin
                            do_write = 1'b1;
                            wr_byte  = ROM_SKIP;
                        end
                        STEP_CONVERT:
                        begin
                            do_write = 1'b1;
                            wr_byte  = FN_CONVERT;
                        end
                        STEP_READ_PAD:
                        begin
                            do_write = 1'b1;
                            wr_byte  = FN_READ_PAD;
                        end
                        STEP_LOW_BYTE, STEP_HIGH_BYTE:
                            do_read = 1'b1;
                        default:
                            do_read = 1'b0;
                    endcase
                end
                default:
                    do_read = 1'b0;
            endcase

            if (do_reset)
            begin
                phase_next = PH_RST_LOW;
                timer_next = clamp_dur(cfg.reset_low_time);
            end
            else if (do_write)
            begin
                shift_next     = wr_byte;
                bit_count_next = 4'd0;
                phase_next     = PH_WR_LOW;
                timer_next     = wr_byte[0] ? clamp_dur(DUR_W'(cfg.short_low_time))
                                            : clamp_dur(DUR_W'(cfg.long_low_time));
            end
            else if (do_read)
            begin
                shift_next     = 8'd0;
                bit_count_next = 4'd0;
                phase_next     = PH_RD_LOW;
                timer_next     = clamp_dur(DUR_W'(cfg.short_low_time));
            end
            else
            begin
                phase_next = PH_IDLE;
                timer_next = '0;
                done       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            step_reg      <= 4'd0;
            command_reg   <= 3'd0;
            low_byte_reg  <= 8'd0;
            status_reg    <= 2'd0;
            temp_reg      <= 16'd0;
            read_reg      <= 8'd0;
        end
        else if (tick_en)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            step_reg      <= step_next;
            command_reg   <= command_next;
            low_byte_reg  <= low_byte_next;
            status_reg    <= status_next;
            temp_reg      <= temp_next;
            read_reg      <= read_next;
        end
    end

    assign res.drive_low       = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                                 (phase_next == PH_RD_LOW);
    assign res.busy_res        = (phase_next != PH_IDLE);
    assign res.done_res        = done;
    assign res.presence_status = status_next;
    assign res.read_data       = read_next;
    assign res.temperature     = signed'(temp_next);

endmodule
